FILE: hw/rtl/mtmf_pkg.sv
// ----------------------------------------------------------------------------
// mtmf_pkg
// Shared widths, types and divider command/status structs for the multichannel trimmed-mean filter.
// ----------------------------------------------------------------------------
package mtmf_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int CHANNEL_W = 3;
    localparam int SUM_W     = 16;

    typedef logic [SAMPLE_W-1:0]  sample_t;
    typedef logic [CHANNEL_W-1:0] channel_t;

    typedef struct packed {
        channel_t channel;
        sample_t  average;
        logic     last;
    } result_t;

    // Command from the sequencer to the divider, and its status back.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [4:0]       divisor;
    } div_cmd_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_sts_t;

endpackage

FILE: hw/rtl/mtmf_stream_if.sv
// ----------------------------------------------------------------------------
// mtmf_stream_if
// Valid/ready channel that carries one payload per beat.
// ----------------------------------------------------------------------------
interface mtmf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/mtmf_divider.sv
// ----------------------------------------------------------------------------
// mtmf_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtmf_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  mtmf_pkg::div_cmd_t cmd,
    output mtmf_pkg::div_sts_t sts
);
    localparam int W = mtmf_pkg::SUM_W;

    logic [W-1:0] quo_reg, quo_next;
    logic [5:0]   rem_reg, rem_next;
    logic [4:0]   den_reg, den_next;
    logic [4:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [5:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[4:0], quo_reg[W-1]};
        if (cmd.start)
        begin
            quo_next  = cmd.dividend;
            rem_next  = '0;
            den_next  = cmd.divisor;
            cnt_next  = 5'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign sts.busy     = busy_reg;
    assign sts.done     = done_reg;
    assign sts.quotient = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without busy");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !cmd.start)
        else $error("divider restarted while busy");
    a_count_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg && !$past(cmd.start) |-> cnt_reg == 5'd0)
        else $error("divider count stale");
endmodule

FILE: hw/rtl/multichannel_trimmed_mean_filter_core.sv
// With a full window an item with results runs, per channel, a rank-count pass and the
// 16-bit serial divider; before that, a running sum over the filled columns and the divider.
// Throughput: one item at a time; in is not ready until every result of the item leaves.
// Reset is asynchronous, active low, and clears state and result registers but not the sample store.
// ----------------------------------------------------------------------------
// multichannel_trimmed_mean_filter_core
// Per-channel sample windows with a trimmed-mean or running-mean output, using
// one shared comparator/adder and a serial divider.
// ----------------------------------------------------------------------------
module multichannel_trimmed_mean_filter_core #(
    parameter int CHANNELS = 2,
    parameter int WINDOW   = 10,
    parameter int TRIM_LOW = 3,
    parameter int KEEP     = 5
) (
    input  logic clk,
    input  logic rst_n,
    mtmf_stream_if.sink   in_ch,
    mtmf_stream_if.source out_ch
);
    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int WIDX  = $clog2(WINDOW + 1);
    localparam int CW    = $clog2(CHANNELS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_OUTER = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_DIVS  = 7'b0001000,
        S_DIVW  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_FETCH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    mtmf_pkg::sample_t store [DEPTH];

    logic [CW-1:0]   slot_reg;
    logic [WIDX-1:0] col_reg;
    logic [4:0]      rounds_reg;
    logic [CW-1:0]   ch_reg;
    logic [WIDX-1:0] i_reg, j_reg;
    logic [WIDX-1:0] rank_reg;
    mtmf_pkg::sample_t vi_reg, rd_reg;
    logic [mtmf_pkg::SUM_W-1:0] sum_reg;
    logic            fetch_i_reg;
    logic            full;

    mtmf_pkg::div_cmd_t div_cmd;
    mtmf_pkg::div_sts_t div_sts;
    mtmf_pkg::result_t  res_reg;
    logic               ovalid_reg;

    mtmf_divider u_div (.clk(clk), .rst_n(rst_n), .cmd(div_cmd), .sts(div_sts));

    assign full = (rounds_reg >= 5'(WINDOW));
    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;

    logic [AW-1:0] rd_addr;
    logic [WIDX-1:0] rd_col;
    assign rd_col  = fetch_i_reg ? i_reg : j_reg;
    assign rd_addr = AW'(32'(ch_reg) * WINDOW + 32'(rd_col));

    always_ff @(posedge clk)
    begin
        rd_reg <= store[rd_addr];
        if (in_ch.valid && in_ch.ready && (32'(slot_reg) < CHANNELS))
            store[AW'(32'(slot_reg) * WINDOW + 32'(col_reg))] <= in_ch.payload;
    end

    // The element at column i is kept when its stable rank (count of smaller
    // entries, ties broken by column) lies within the kept band.
    logic ahead;
    assign ahead = (rd_reg < vi_reg) || ((rd_reg == vi_reg) && (j_reg < i_reg));

    always_comb
    begin
        div_cmd.start    = (state_reg == S_DIVS);
        div_cmd.dividend = sum_reg;
        div_cmd.divisor  = full ? 5'(KEEP) : rounds_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            slot_reg    <= '0;
            col_reg     <= '0;
            rounds_reg  <= '0;
            ovalid_reg  <= 1'b0;
            fetch_i_reg <= 1'b0;
            ch_reg      <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            rank_reg    <= '0;
            vi_reg      <= '0;
            sum_reg     <= '0;
            res_reg     <= '0;
        end
        else
        begin
            if (ovalid_reg && out_ch.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        ch_reg  <= '0;
                        sum_reg <= '0;
                        i_reg   <= '0;
                        if (32'(slot_reg) < CHANNELS)
                        begin
                            slot_reg <= slot_reg + CW'(1);
                            if (rounds_reg != 5'd0)
                            begin
                                fetch_i_reg <= 1'b1;
                                state_reg   <= S_FETCH;
                            end
                        end
                        else
                        begin
                            slot_reg <= '0;
                            col_reg  <= (32'(col_reg) == WINDOW - 1) ? '0
                                                                  : col_reg + WIDX'(1);
                            if (rounds_reg < 5'(WINDOW))
                                rounds_reg <= rounds_reg + 5'd1;
                            fetch_i_reg <= 1'b1;
                            state_reg   <= S_FETCH;
                        end
                    end
                end
                S_FETCH:
                begin
                    // Read latency slot for column i.
                    fetch_i_reg <= 1'b0;
                    j_reg       <= '0;
                    rank_reg    <= '0;
                    state_reg   <= S_OUTER;
                end
                S_OUTER:
                begin
                    // Column i is on the read port only at the start of a pass.
                    if (j_reg == '0)
                        vi_reg <= rd_reg;
                    if (full)
                        state_reg <= S_CMP;
                    else
                    begin
                        sum_reg <= sum_reg + mtmf_pkg::SUM_W'(rd_reg);
                        if (5'(i_reg) + 5'd1 >= rounds_reg)
                            state_reg <= S_DIVS;
                        else
                        begin
                            i_reg       <= i_reg + WIDX'(1);
                            fetch_i_reg <= 1'b1;
                            state_reg   <= S_FETCH;
                        end
                    end
                end
                S_CMP:
                begin
                    // rd_reg holds column j, read from the port during OUTER.
                    if (ahead)
                        rank_reg <= rank_reg + WIDX'(1);
                    if (32'(j_reg) == WINDOW - 1)
                    begin
                        if ((32'(rank_reg) + (ahead ? 1 : 0) >= TRIM_LOW) &&
                            (32'(rank_reg) + (ahead ? 1 : 0) < TRIM_LOW + KEEP))
                            sum_reg <= sum_reg + mtmf_pkg::SUM_W'(vi_reg);
                        if (32'(i_reg) == WINDOW - 1)
                            state_reg <= S_DIVS;
                        else
                        begin
                            i_reg       <= i_reg + WIDX'(1);
                            fetch_i_reg <= 1'b1;
                            state_reg   <= S_FETCH;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + WIDX'(1);
                        state_reg <= S_OUTER;
                    end
                end
                S_DIVS:
                    state_reg <= S_DIVW;
                S_DIVW:
                begin
                    if (div_sts.done && !ovalid_reg)
                    begin
                        res_reg.channel <= mtmf_pkg::CHANNEL_W'(ch_reg);
                        res_reg.average <= div_sts.quotient[mtmf_pkg::SAMPLE_W-1:0];
                        res_reg.last    <= (32'(ch_reg) == CHANNELS - 1);
                        ovalid_reg      <= 1'b1;
                        state_reg       <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (32'(ch_reg) == CHANNELS - 1)
                        state_reg <= S_IDLE;
                    else if (!ovalid_reg)
                    begin
                        ch_reg      <= ch_reg + CW'(1);
                        sum_reg     <= '0;
                        i_reg       <= '0;
                        fetch_i_reg <= 1'b1;
                        state_reg   <= S_FETCH;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // In the compare loop OUTER waits for the read of the next column j and, at the start of a
    // pass, loads column i into vi_reg; vi_reg keeps column i for the whole pass.
    assign out_ch.valid   = ovalid_reg;
    assign out_ch.payload = res_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ch.ready |=> ovalid_reg && $stable(res_reg))
        else $error("result dropped");
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_reg) <= CHANNELS)
        else $error("slot out of range");
    a_rounds_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rounds_reg <= 5'(WINDOW))
        else $error("round count past window");
endmodule
